// ===== design/scb_pkg.sv =====
// Types and constants shared by the screen blend compositor.
package scb_pkg;

   localparam int ChanCount = 3;
   localparam int ChanWidth = 8;
   localparam int QuoBits   = 8;
   localparam int RemWidth  = 17;
   localparam int DivWidth  = 16;

   // Reciprocals for the exact division by 255 at three operand widths.
   localparam logic [15:0] Recip255W16 = 16'd32897;
   localparam logic [31:0] Recip255W32 = 32'h80808081;
   localparam logic [24:0] Recip255W24 = 25'd16843010;
   localparam logic [31:0] HalfScale2  = 32'd32512;
   localparam logic [16:0] HalfScale1  = 17'd127;

   typedef struct packed {
      logic [7:0] first_red;
      logic [7:0] first_green;
      logic [7:0] first_blue;
      logic [7:0] first_alpha;
      logic [7:0] second_red;
      logic [7:0] second_green;
      logic [7:0] second_blue;
      logic [7:0] second_alpha;
   } pixel_pair_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } pixel_out_type;

   typedef struct packed {
      logic                                    bypass;
      pixel_out_type                           bypass_pix;
      logic [7:0]                              alpha;
      logic [ChanCount-1:0]                    sat;
      logic [ChanCount-1:0][RemWidth-1:0]      rem;
      logic [DivWidth-1:0]                     dv;
      logic [ChanCount-1:0][QuoBits-1:0]       quo;
   } div_type;

endpackage

// ===== design/scb_front.sv =====
// Premultiply, screen blend and alpha composite stages ahead of the divider chain.
module scb_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  scb_pkg::pixel_pair_type in_pix,
   output logic                   out_valid,
   output scb_pkg::div_type       out_data
);

   // Stage 1: premultiplied channels and the alpha product.
   logic                         v1_ff;
   logic [2:0][15:0]             pa1_ff, pb1_ff;
   logic [15:0]                  xa1_ff;
   logic [8:0]                   asum1_ff;
   logic                         byp1_ff;
   scb_pkg::pixel_out_type       bpix1_ff;

   // Stage 2: product of premultiplied values with the rounding offset, composited alpha.
   logic                         v2_ff;
   logic [2:0][31:0]             n2_ff;
   logic [2:0][16:0]             psum2_ff;
   logic [7:0]                   a2_ff;
   logic                         byp2_ff;
   scb_pkg::pixel_out_type       bpix2_ff;

   // Stage 3: first division by 255.
   logic                         v3_ff;
   logic [2:0][23:0]             t3_ff;
   logic [2:0][16:0]             psum3_ff;
   logic [7:0]                   a3_ff;
   logic                         byp3_ff;
   scb_pkg::pixel_out_type       bpix3_ff;

   // Stage 4: second division by 255 and the blended value.
   logic                         v4_ff;
   logic [2:0][16:0]             s4_ff;
   logic [7:0]                   a4_ff;
   logic                         byp4_ff;
   scb_pkg::pixel_out_type       bpix4_ff;

   // Stage 5: divider set-up.
   logic                         v5_ff;
   scb_pkg::div_type             d5_ff;

   logic [2:0][7:0]              ca, cb;
   logic [2:0][15:0]             pa1_in, pb1_in;
   scb_pkg::pixel_out_type       first_pix, second_pix, bpix1_in;
   logic                         byp1_in;
   logic [2:0][31:0]             n2_in;
   logic [2:0][16:0]             psum2_in;
   logic [31:0]                  aprod;
   logic [7:0]                   a2_in;
   logic [2:0][63:0]             t3_prod;
   logic [2:0][23:0]             t3_in;
   logic [2:0][55:0]             r4_prod;
   logic [2:0][16:0]             s4_in;
   scb_pkg::div_type             d5_in;
   logic [2:0][17:0]             num;
   logic [17:0]                  sat_lim;

   assign ca = {in_pix.first_red, in_pix.first_green, in_pix.first_blue};
   assign cb = {in_pix.second_red, in_pix.second_green, in_pix.second_blue};
   assign first_pix  = {in_pix.first_red, in_pix.first_green, in_pix.first_blue,
                        in_pix.first_alpha};
   assign second_pix = {in_pix.second_red, in_pix.second_green, in_pix.second_blue,
                        in_pix.second_alpha};

   always_comb begin
      for (int i = 0; i < scb_pkg::ChanCount; i++) begin
         pa1_in[i] = 16'(ca[i]) * 16'(in_pix.first_alpha);
         pb1_in[i] = 16'(cb[i]) * 16'(in_pix.second_alpha);
      end
      // A transparent pixel hands the other one through untouched.
      byp1_in  = (in_pix.first_alpha == 8'd0) || (in_pix.second_alpha == 8'd0);
      bpix1_in = (in_pix.first_alpha == 8'd0) ? second_pix : first_pix;
   end

   always_comb begin
      for (int i = 0; i < scb_pkg::ChanCount; i++) begin
         n2_in[i]    = 32'(pa1_ff[i]) * 32'(pb1_ff[i]) + scb_pkg::HalfScale2;
         psum2_in[i] = 17'(pa1_ff[i]) + 17'(pb1_ff[i]);
      end
      aprod = 32'(17'(xa1_ff) + scb_pkg::HalfScale1) * 32'(scb_pkg::Recip255W16);
      a2_in = 8'(asum1_ff - 9'(aprod[30:23]));
   end

   always_comb begin
      for (int i = 0; i < scb_pkg::ChanCount; i++) begin
         t3_prod[i] = 64'(n2_ff[i]) * 64'(scb_pkg::Recip255W32);
         t3_in[i]   = t3_prod[i][62:39];
      end
   end

   always_comb begin
      for (int i = 0; i < scb_pkg::ChanCount; i++) begin
         r4_prod[i] = 56'(t3_ff[i]) * 56'(scb_pkg::Recip255W24);
         s4_in[i]   = psum3_ff[i] - 17'(r4_prod[i][47:32]);
      end
   end

   // The quotient is floor((2S + A) / 2A); it saturates when it would reach 256.
   always_comb begin
      sat_lim          = 18'(a4_ff) << 9;
      d5_in.bypass     = byp4_ff;
      d5_in.bypass_pix = bpix4_ff;
      d5_in.alpha      = a4_ff;
      d5_in.dv         = 16'(a4_ff) << 8;
      d5_in.quo        = '0;
      for (int i = 0; i < scb_pkg::ChanCount; i++) begin
         num[i]       = (18'(s4_ff[i]) << 1) + 18'(a4_ff);
         d5_in.sat[i] = (num[i] >= sat_lim);
         d5_in.rem[i] = num[i][16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      pa1_ff   <= pa1_in;
      pb1_ff   <= pb1_in;
      xa1_ff   <= 16'(in_pix.first_alpha) * 16'(in_pix.second_alpha);
      asum1_ff <= 9'(in_pix.first_alpha) + 9'(in_pix.second_alpha);
      byp1_ff  <= byp1_in;
      bpix1_ff <= bpix1_in;

      n2_ff    <= n2_in;
      psum2_ff <= psum2_in;
      a2_ff    <= a2_in;
      byp2_ff  <= byp1_ff;
      bpix2_ff <= bpix1_ff;

      t3_ff    <= t3_in;
      psum3_ff <= psum2_ff;
      a3_ff    <= a2_ff;
      byp3_ff  <= byp2_ff;
      bpix3_ff <= bpix2_ff;

      s4_ff    <= s4_in;
      a4_ff    <= a3_ff;
      byp4_ff  <= byp3_ff;
      bpix4_ff <= bpix3_ff;

      d5_ff    <= d5_in;
   end

   assign out_valid = v5_ff;
   assign out_data  = d5_ff;

endmodule

// ===== design/scb_cell.sv =====
// One restoring division cell: settles one quotient bit for each colour channel.
module scb_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  scb_pkg::div_type in_data,
   output logic             out_valid,
   output scb_pkg::div_type out_data
);

   logic             valid_ff;
   scb_pkg::div_type data_ff, data_in;
   logic [2:0]       take;

   always_comb begin
      data_in    = in_data;
      data_in.dv = in_data.dv >> 1;
      for (int i = 0; i < scb_pkg::ChanCount; i++) begin
         take[i]           = (in_data.rem[i] >= 17'(in_data.dv));
         data_in.rem[i]    = take[i] ? (in_data.rem[i] - 17'(in_data.dv)) : in_data.rem[i];
         data_in.quo[i]    = {in_data.quo[i][scb_pkg::QuoBits-2:0], take[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/screen_blend_composite.sv =====
// Screen blend with alpha compositing of two RGBA8 pixels, fully pipelined.
// Throughput: one word per clock; busy stays low, the pipeline never stalls.
// The depth is set by five arithmetic stages, eight divider cells and the output register.
// Synchronous reset clears all valid bits; no result appears until a word is taken.
module screen_blend_composite (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  scb_pkg::pixel_pair_type req_pixels,
   output logic                    rsp_valid,
   output scb_pkg::pixel_out_type  rsp_pixel
);

   logic                   valid_chain [scb_pkg::QuoBits+1];
   scb_pkg::div_type       data_chain  [scb_pkg::QuoBits+1];
   logic                   rsp_valid_ff;
   scb_pkg::pixel_out_type rsp_pixel_ff, rsp_pixel_in;
   scb_pkg::div_type       last;

   assign busy = 1'b0;

   scb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_pix    (req_pixels),
      .out_valid (valid_chain[0]),
      .out_data  (data_chain[0])
   );

   for (genvar k = 0; k < scb_pkg::QuoBits; k++) begin : g_cell
      scb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_chain[k]),
         .in_data   (data_chain[k]),
         .out_valid (valid_chain[k+1]),
         .out_data  (data_chain[k+1])
      );
   end

   assign last = data_chain[scb_pkg::QuoBits];

   always_comb begin
      rsp_pixel_in.out_red   = last.sat[2] ? 8'hFF : last.quo[2];
      rsp_pixel_in.out_green = last.sat[1] ? 8'hFF : last.quo[1];
      rsp_pixel_in.out_blue  = last.sat[0] ? 8'hFF : last.quo[0];
      rsp_pixel_in.out_alpha = last.alpha;
      if (last.bypass) begin
         rsp_pixel_in = last.bypass_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_chain[scb_pkg::QuoBits];
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;

endmodule
